// ===== src/pam_pkg.sv =====
// Shared types, constants and helpers for the packet address masker.
package pam_pkg;

  localparam int MAX_FRAME_BYTES = 16384;
  localparam int POS_LIMIT       = 16384;

  localparam logic [14:0] FRAME_LIMIT_RESET = 15'd784;

  localparam logic [15:0] TYPE_VLAN = 16'h8100;
  localparam logic [15:0] TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] TYPE_IPV6 = 16'h86DD;

  // Byte offsets within the frame
  localparam logic [13:0] POS_MAC_END   = 14'd12;  // MAC bytes are 0..11
  localparam logic [13:0] POS_TYPE_HI   = 14'd12;
  localparam logic [13:0] POS_TYPE_LO   = 14'd13;
  localparam logic [13:0] POS_INNER_HI  = 14'd16;
  localparam logic [13:0] POS_INNER_LO  = 14'd17;
  localparam logic [13:0] L3_PLAIN      = 14'd14;
  localparam logic [13:0] L3_VLAN       = 14'd18;

  // Address windows relative to the layer-3 header
  localparam logic [13:0] IPV4_ADDR_LO  = 14'd12;
  localparam logic [13:0] IPV4_ADDR_LEN = 14'd8;
  localparam logic [13:0] IPV6_ADDR_LO  = 14'd8;
  localparam logic [13:0] IPV6_ADDR_LEN = 14'd40 - 14'd8;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_IPV4  = 2'd1,
    KIND_IPV6  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [13:0] byte_offset;
    logic [15:0] outer_type;
    logic        has_vlan;
    kind_t       net_kind;
    logic        limit_reached;
  } frame_state_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        masked;
    logic [13:0] position;
    logic        frame_end;
  } result_t;

  function automatic kind_t kind_of(input logic [15:0] etype);
    kind_t k;
    k = KIND_OTHER;
    if (etype == TYPE_IPV4) k = KIND_IPV4;
    else if (etype == TYPE_IPV6) k = KIND_IPV6;
    return k;
  endfunction

endpackage

// ===== src/pam_classify.sv =====
// Per-byte header parsing, address masking and frame state update.
module pam_classify #(
  parameter int MAX_FRAME_BYTES = pam_pkg::MAX_FRAME_BYTES
) (
  input  pam_pkg::frame_state_t st,
  input  logic [14:0]           frame_limit,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  output pam_pkg::frame_state_t st_next,
  output logic                  emit,
  output pam_pkg::result_t      res
);

  localparam int CAP_RAW = (MAX_FRAME_BYTES > pam_pkg::POS_LIMIT) ?
                           pam_pkg::POS_LIMIT : MAX_FRAME_BYTES;
  localparam int CAP     = (CAP_RAW < 1) ? 1 : CAP_RAW;
  localparam logic [14:0] LIM_CAP = 15'(CAP);

  logic [14:0] lim;
  logic [14:0] pos_ext;
  logic [14:0] pos_inc;
  logic [13:0] pos;
  logic [13:0] l3;
  logic        at_limit;
  logic        mask;
  logic [15:0] assembled;

  always_comb begin
    if (frame_limit == 15'd0) lim = 15'd1;
    else if (frame_limit > LIM_CAP) lim = LIM_CAP;
    else lim = frame_limit;
  end

  assign pos       = st.byte_offset;
  assign pos_ext   = {1'b0, pos};
  assign pos_inc   = pos_ext + 15'd1;
  assign at_limit  = (pos_inc == lim);
  assign l3        = st.has_vlan ? pam_pkg::L3_VLAN : pam_pkg::L3_PLAIN;
  assign assembled = {st.outer_type[15:8], data_byte};

  always_comb begin
    st_next = st;
    emit    = 1'b0;
    mask    = 1'b0;

    if (st.limit_reached || pos_ext >= lim) begin
      // drop the byte; end of frame still clears state
      st_next.limit_reached = 1'b1;
      if (last_byte) st_next = '0;
    end else begin
      emit = 1'b1;
      if (pos < pam_pkg::POS_MAC_END) begin
        mask = 1'b1;
      end else if (pos == pam_pkg::POS_TYPE_HI) begin
        st_next.outer_type = {data_byte, 8'h00};
      end else if (pos == pam_pkg::POS_TYPE_LO) begin
        st_next.outer_type = assembled;
        if (assembled == pam_pkg::TYPE_VLAN) st_next.has_vlan = 1'b1;
        else st_next.net_kind = pam_pkg::kind_of(assembled);
      end else if (st.has_vlan && pos == pam_pkg::POS_INNER_HI) begin
        st_next.outer_type = {data_byte, 8'h00};
      end else if (st.has_vlan && pos == pam_pkg::POS_INNER_LO) begin
        st_next.outer_type = assembled;
        st_next.net_kind   = pam_pkg::kind_of(assembled);
      end else begin
        if (st.net_kind == pam_pkg::KIND_IPV4 &&
            pos >= l3 + pam_pkg::IPV4_ADDR_LO &&
            pos <  l3 + pam_pkg::IPV4_ADDR_LO + pam_pkg::IPV4_ADDR_LEN)
          mask = 1'b1;
        if (st.net_kind == pam_pkg::KIND_IPV6 &&
            pos >= l3 + pam_pkg::IPV6_ADDR_LO &&
            pos <  l3 + pam_pkg::IPV6_ADDR_LO + pam_pkg::IPV6_ADDR_LEN)
          mask = 1'b1;
      end

      if (last_byte) begin
        st_next = '0;
      end else begin
        st_next.byte_offset = pos_inc[13:0];
        if (at_limit) st_next.limit_reached = 1'b1;
      end
    end
  end

  assign res.out_byte  = mask ? 8'h00 : data_byte;
  assign res.masked    = mask;
  assign res.position  = pos;
  assign res.frame_end = last_byte || at_limit;

endmodule

// ===== src/packet_address_masker.sv =====
// Streaming Ethernet/IP address masker: one frame byte in, at most one byte out.
//
// Accepts one byte per clock and emits at most one result per clock when the output
// side keeps up; each byte passes an input register, then a result register.
// MAC bytes are always zeroed, and IPv4 or IPv6 source/destination addresses are
// zeroed once the EtherType (optionally behind one VLAN tag) is known. Bytes past
// the frame limit produce no result; the byte at the limit carries frame_end.
// The user must write frame_limit through cfg_write/cfg_data only while the block is
// idle (not enforced by the block); zero acts as one, values above the supported frame size are capped.
module packet_address_masker #(
  parameter int MAX_FRAME_BYTES = pam_pkg::MAX_FRAME_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [14:0] cfg_data,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [7:0]  out_byte,
  output logic        masked,
  output logic [13:0] position,
  output logic        frame_end
);

  logic [14:0]           frame_limit;
  logic                  s1_valid;
  logic [7:0]            s1_byte;
  logic                  s1_last;
  pam_pkg::frame_state_t st;
  pam_pkg::frame_state_t st_next;
  logic                  emit;
  pam_pkg::result_t      res;
  logic                  advance;

  assign advance    = s1_valid && (!result_valid || result_ready);
  assign byte_ready = !s1_valid || advance;

  pam_classify #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_classify (
    .st         (st),
    .frame_limit(frame_limit),
    .data_byte  (s1_byte),
    .last_byte  (s1_last),
    .st_next    (st_next),
    .emit       (emit),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit  <= pam_pkg::FRAME_LIMIT_RESET;
      s1_valid     <= 1'b0;
      st           <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write) frame_limit <= cfg_data;

      if (byte_valid && byte_ready) begin
        s1_valid <= 1'b1;
        s1_byte  <= data_byte;
        s1_last  <= last_byte;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end

      if (advance && emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      if (advance) begin
        st <= st_next;
        if (emit) begin
          out_byte     <= res.out_byte;
          masked       <= res.masked;
          position     <= res.position;
          frame_end    <= res.frame_end;
        end
      end
    end
  end

endmodule

// ===== src/packet_address_masker_checker.sv =====
// Port-level checks for the packet address masker, bound to the top level.
module packet_address_masker_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input logic [7:0]  out_byte,
  input logic        masked,
  input logic [13:0] position,
  input logic        frame_end
);

  // hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(out_byte) &&
      $stable(masked) && $stable(position) && $stable(frame_end))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && masked |-> out_byte == 8'h00)
    else $error("masked byte not zero");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && position < 14'd12 |-> masked)
    else $error("MAC byte not masked");

  assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind packet_address_masker packet_address_masker_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .out_byte    (out_byte),
  .masked      (masked),
  .position    (position),
  .frame_end   (frame_end)
);
